// File: hw/rtl/bdqs_pkg.sv
// Shared types and constants of the bounded deque with search.
// Holds command and status codes and the packing of the stream words.
// No dependencies.
package bdqs_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CONTAINS   = 3'd4,
        CMD_REMOVE     = 3'd5,
        CMD_QUERY      = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam int CMD_BITS   = 3;
    localparam int FIELD_BITS = 32;
    localparam int TOTAL_BITS = 5;

    // Input word: command [2:0], value [34:3], zero fill to 40 bits
    localparam int S_DATA_BITS = 40;
    localparam int S_CMD_LSB   = 0;
    localparam int S_VAL_LSB   = 3;

    // Output word: status [1:0], found [2], front [34:3], back [66:35],
    // entry_total [71:67], is_empty [72], zero fill to 80 bits
    localparam int M_DATA_BITS  = 80;
    localparam int M_STAT_LSB   = 0;
    localparam int M_FOUND_BIT  = 2;
    localparam int M_FRONT_LSB  = 3;
    localparam int M_BACK_LSB   = 35;
    localparam int M_TOTAL_LSB  = 67;
    localparam int M_EMPTY_BIT  = 72;

endpackage

// File: hw/rtl/bounded_deque_with_search_unit.sv
// Push, pop and query go from EXEC through FETCH to DONE, which registers the result word.
// Contains and remove first walk the entries in SCAN from the front up to the first match,
// or past every held entry on a miss. A remove that hits then closes the gap in COMPACT,
// shifting each later entry one place toward the front, before FETCH.
// One word is in flight at a time: input is taken only in IDLE, and a stalled result holds input.
// Reset: aresetn low (synchronous) empties the deque; the memory is not cleared.
//
// Top level of the bounded double-ended queue with membership search.
// Depends on bdqs_pkg.
module bounded_deque_with_search_unit
    import bdqs_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // s_tdata: command [2:0], value [34:3], zero [39:35]
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // m_tdata: status [1:0], found [2], front_value [34:3], back_value [66:35],
    //          entry_total [71:67], is_empty [72], zero [79:73]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_SCAN    = 6'b000100,
        S_COMPACT = 6'b001000,
        S_FETCH   = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          front_reg, front_next;
    logic [CW-1:0]          count_reg, count_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0]  val_reg, val_next;
    status_t                status_reg, status_next;
    logic                   found_reg, found_next;
    // Walk pointer: offset from the front of the next read to issue
    logic [CW-1:0]          rd_ptr_reg, rd_ptr_next;
    // Offset of the read whose data lands this cycle
    logic                   pend_valid_reg, pend_valid_next;
    logic [CW-1:0]          pend_idx_reg, pend_idx_next;

    logic                   m_tvalid_reg;
    logic [M_DATA_BITS-1:0] m_tdata_reg;
    logic [M_DATA_BITS-1:0] result_word;

    // Value memory: one write port, two registered read ports
    logic [VALUE_BITS-1:0]  value_mem [DEPTH];
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_BITS-1:0]  wr_data;
    logic                   rd_a_en, rd_b_en;
    logic [AW-1:0]          rd_a_addr, rd_b_addr;
    logic [VALUE_BITS-1:0]  rd_a_data_reg, rd_b_data_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   is_full, is_none;
    logic [63:0]            in_val_wide;
    logic [63:0]            front_wide, back_wide, total_wide;

    // Circular index: base plus offset, both below DEPTH, folded once
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Hold ready low while reset is asserted so no word is taken and lost
    assign s_tready    = aresetn && (state_reg == S_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign is_full     = (count_reg == CW'(DEPTH));
    assign is_none     = (count_reg == '0);
    assign in_val_wide = 64'(s_tdata[S_VAL_LSB +: FIELD_BITS]);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[wr_addr] <= wr_data;
        end
        if (rd_a_en) begin
            rd_a_data_reg <= value_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_data_reg <= value_mem[rd_b_addr];
        end
    end

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = wrap_add(front_reg, count_reg);
        wr_data         = val_reg;
        rd_a_en         = 1'b0;
        rd_a_addr       = wrap_add(front_reg, rd_ptr_reg);
        rd_b_en         = 1'b0;
        rd_b_addr       = wrap_add(front_reg, count_reg - CW'(1));

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next    = cmd_t'(s_tdata[S_CMD_LSB +: CMD_BITS]);
                    val_next    = VALUE_BITS'(in_val_wide);
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_FETCH;
                unique case (cmd_reg)
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (cmd_reg == CMD_PUSH_FRONT) begin
                                // Step the front back one place and store there
                                wr_addr    = wrap_add(front_reg, CW'(DEPTH - 1));
                                front_next = wrap_add(front_reg, CW'(DEPTH - 1));
                            end
                        end
                    end
                    CMD_POP_FRONT, CMD_POP_BACK: begin
                        if (is_none) begin
                            status_next = ST_EMPTY;
                        end else begin
                            count_next = count_reg - CW'(1);
                            if (cmd_reg == CMD_POP_FRONT) begin
                                front_next = wrap_add(front_reg, CW'(1));
                            end
                        end
                    end
                    CMD_CONTAINS, CMD_REMOVE: begin
                        if (is_none) begin
                            status_next = ST_EMPTY;
                        end else begin
                            rd_ptr_next     = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                    end
                    default: begin
                        // Query and the unused code: report only
                    end
                endcase
            end

            S_SCAN: begin
                // Issue one read per cycle, compare the one that lands
                rd_a_en         = (rd_ptr_reg < count_reg);
                pend_valid_next = (rd_ptr_reg < count_reg);
                pend_idx_next   = rd_ptr_reg;
                if (rd_ptr_reg < count_reg) begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                if (pend_valid_reg && (rd_a_data_reg == val_reg)) begin
                    found_next = 1'b1;
                    if (cmd_reg == CMD_REMOVE) begin
                        // Drop the in-flight read; restart just past the hit
                        rd_ptr_next     = pend_idx_reg + CW'(1);
                        pend_valid_next = 1'b0;
                        state_next      = S_COMPACT;
                    end else begin
                        state_next = S_FETCH;
                    end
                end else if (!pend_valid_reg && (rd_ptr_reg == count_reg)) begin
                    state_next = S_FETCH;
                end
            end

            S_COMPACT: begin
                // Write the word landed from offset i+1 back to offset i while the next read issues
                rd_a_en         = (rd_ptr_reg < count_reg);
                pend_valid_next = (rd_ptr_reg < count_reg);
                pend_idx_next   = rd_ptr_reg;
                if (rd_ptr_reg < count_reg) begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                if (pend_valid_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = wrap_add(front_reg, pend_idx_reg - CW'(1));
                    wr_data = rd_a_data_reg;
                end else if (rd_ptr_reg == count_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FETCH;
                end
            end

            S_FETCH: begin
                // Read front and back of the updated deque
                rd_a_en    = 1'b1;
                rd_a_addr  = front_reg;
                rd_b_en    = 1'b1;
                state_next = S_DONE;
            end

            S_DONE: begin
                // Hold here until the output register frees up
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rd_ptr_reg   <= rd_ptr_next;
        pend_idx_reg <= pend_idx_next;
    end

    // Result packing; an empty deque shows zero values
    assign front_wide = is_none ? 64'd0 : 64'(rd_a_data_reg);
    assign back_wide  = is_none ? 64'd0 : 64'(rd_b_data_reg);
    assign total_wide = 64'(count_reg);

    always_comb begin
        result_word                            = '0;
        result_word[M_STAT_LSB +: 2]           = status_reg;
        result_word[M_FOUND_BIT]               = found_reg;
        result_word[M_FRONT_LSB +: FIELD_BITS] = front_wide[FIELD_BITS-1:0];
        result_word[M_BACK_LSB +: FIELD_BITS]  = back_wide[FIELD_BITS-1:0];
        result_word[M_TOTAL_LSB +: TOTAL_BITS] = total_wide[TOTAL_BITS-1:0];
        result_word[M_EMPTY_BIT]               = is_none;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && out_free) begin
            m_tdata_reg <= result_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: hw/rtl/bdqs_checker.sv
// Port-level checks for the bounded deque with search, bound to the top level.
// Depends on bdqs_pkg and bounded_deque_with_search_unit.
module bdqs_checker
    import bdqs_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_DATA_BITS-1:0] s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata
);

    logic [1:0]            stat;
    logic                  found;
    logic                  empty;
    logic [TOTAL_BITS-1:0] total;
    logic [FIELD_BITS-1:0] front_v, back_v;

    assign stat    = m_tdata[M_STAT_LSB +: 2];
    assign found   = m_tdata[M_FOUND_BIT];
    assign empty   = m_tdata[M_EMPTY_BIT];
    assign total   = m_tdata[M_TOTAL_LSB +: TOTAL_BITS];
    assign front_v = m_tdata[M_FRONT_LSB +: FIELD_BITS];
    assign back_v  = m_tdata[M_BACK_LSB +: FIELD_BITS];

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && empty |-> (front_v == '0) && (back_v == '0) && (total == '0))
        else $error("empty deque shows values or count");

    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == ST_EMPTY) |-> empty && !found)
        else $error("refused operation on a non-empty deque");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && found |-> (stat == ST_OK))
        else $error("match reported with a failing status");

    a_full_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (stat == ST_FULL) |-> !empty && !found)
        else $error("full status on an empty deque");

endmodule

bind bounded_deque_with_search_unit bdqs_checker u_bdqs_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for bounded_deque_with_search_unit.
// Mirrors the deque in a behavioral shadow, drives commands over the input stream
// and checks every result word field by field. Depends on bdqs_pkg and the RTL top.
module tb;
    import bdqs_pkg::*;

    localparam int          DQ_DEPTH    = 16;
    localparam int          DQ_VAL_BITS = 32;
    localparam int          CLK_HALF    = 6;
    localparam int          RST_CYCLES  = 12;
    localparam int          IDLE_MAX    = 13;
    localparam int          HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Unused command code; the block treats it as a query
    localparam logic [CMD_BITS-1:0] CMD_SPARE = 3'd7;

    // One expected result word, unpacked
    typedef struct {
        logic [CMD_BITS-1:0]   cmd;
        status_t               status;
        logic                  found;
        logic [FIELD_BITS-1:0] front;
        logic [FIELD_BITS-1:0] back;
        logic [TOTAL_BITS-1:0] total;
        logic                  empty;
    } deque_view_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: command [2:0], value [34:3], zero [39:35]
    logic [S_DATA_BITS-1:0] s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: status [1:0], found [2], front_value [34:3], back_value [66:35],
    //          entry_total [71:67], is_empty [72], zero [79:73]
    logic [M_DATA_BITS-1:0] m_tdata;

    // Shadow copy of the deque contents
    logic [DQ_VAL_BITS-1:0] mirror_vals [DQ_DEPTH];
    int unsigned            mirror_front = 0;
    int unsigned            mirror_count = 0;

    // Results predicted but not yet seen on the output stream
    deque_view_t expected_views [$];

    // Idle knobs for the sender (gap) and the receiver (stall and hold)
    int unsigned gap_max      = IDLE_MAX;
    int unsigned stall_max    = IDLE_MAX;
    int unsigned hold_request = 0;

    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned full_drops     = 0;
    int unsigned empty_refusals = 0;
    int unsigned search_hits    = 0;
    int unsigned cmd_seen [8]   = '{default: 0};
    int unsigned cycle_count    = 0;

    bounded_deque_with_search_unit #(
        .DEPTH      (DQ_DEPTH),
        .VALUE_BITS (DQ_VAL_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Map a distance from the front onto a store slot
    function automatic int unsigned slot_of(int unsigned offset);
        return (mirror_front + offset) % DQ_DEPTH;
    endfunction

    // Apply one command to the shadow deque and return the word it should produce
    function automatic deque_view_t apply_deque_command(logic [CMD_BITS-1:0] cmd,
                                                         logic [DQ_VAL_BITS-1:0] val);
        deque_view_t view;
        int unsigned hit;
        view.cmd    = cmd;
        view.status = ST_OK;
        view.found  = 1'b0;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (mirror_count >= DQ_DEPTH) begin
                    // drop the value, leave the store untouched
                    view.status = ST_FULL;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    mirror_front = (mirror_front + DQ_DEPTH - 1) % DQ_DEPTH;
                    mirror_vals[mirror_front] = val;
                    mirror_count++;
                end else begin
                    mirror_vals[slot_of(mirror_count)] = val;
                    mirror_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_CONTAINS, CMD_REMOVE: begin
                if (mirror_count == 0) begin
                    view.status = ST_EMPTY;
                end else if (cmd == CMD_POP_FRONT) begin
                    mirror_front = slot_of(1);
                    mirror_count--;
                end else if (cmd == CMD_POP_BACK) begin
                    mirror_count--;
                end else begin
                    // first match counted from the front
                    hit = mirror_count;
                    for (int unsigned i = 0; i < mirror_count; i++) begin
                        if (hit == mirror_count && mirror_vals[slot_of(i)] == val) begin
                            hit = i;
                        end
                    end
                    if (hit < mirror_count) begin
                        view.found = 1'b1;
                        if (cmd == CMD_REMOVE) begin
                            // close the gap toward the front
                            for (int unsigned i = hit; i + 1 < mirror_count; i++) begin
                                mirror_vals[slot_of(i)] = mirror_vals[slot_of(i + 1)];
                            end
                            mirror_count--;
                        end
                    end
                end
            end
            default: begin
                // query and the spare code leave the state alone
            end
        endcase
        if (mirror_count == 0) begin
            view.front = '0;
            view.back  = '0;
        end else begin
            view.front = mirror_vals[mirror_front];
            view.back  = mirror_vals[slot_of(mirror_count - 1)];
        end
        view.total = mirror_count[TOTAL_BITS-1:0];
        view.empty = (mirror_count == 0);
        return view;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(string name, logic [FIELD_BITS-1:0] got,
                                 logic [FIELD_BITS-1:0] want, logic [CMD_BITS-1:0] cmd);
        if (got !== want) begin
            flag_mismatch($sformatf("result %0d (cmd %0d) %s: got %h want %h",
                                    results_seen, cmd, name, got, want));
        end
    endtask

    // Compare one accepted result word against the oldest prediction
    task automatic check_view(logic [M_DATA_BITS-1:0] word);
        deque_view_t want;
        if (expected_views.size() == 0) begin
            flag_mismatch($sformatf("result word with nothing pending: %h", word));
            return;
        end
        want = expected_views.pop_front();
        results_seen++;
        compare_field("status", FIELD_BITS'(word[M_STAT_LSB +: 2]),
                      FIELD_BITS'(want.status), want.cmd);
        compare_field("found", FIELD_BITS'(word[M_FOUND_BIT]),
                      FIELD_BITS'(want.found), want.cmd);
        compare_field("front_value", word[M_FRONT_LSB +: FIELD_BITS], want.front, want.cmd);
        compare_field("back_value", word[M_BACK_LSB +: FIELD_BITS], want.back, want.cmd);
        compare_field("entry_total", FIELD_BITS'(word[M_TOTAL_LSB +: TOTAL_BITS]),
                      FIELD_BITS'(want.total), want.cmd);
        compare_field("is_empty", FIELD_BITS'(word[M_EMPTY_BIT]),
                      FIELD_BITS'(want.empty), want.cmd);
    endtask

    // Receiver: accept result words, stall at random, and honor a long hold-off
    // when a test asks for one. The hold is counted here, cycle by cycle.
    initial begin
        int unsigned stall_left;
        bit          took;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            took = (m_tvalid === 1'b1) && (m_tready === 1'b1);
            if (took) begin
                check_view(m_tdata);
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (took) begin
                stall_left = $urandom_range(0, stall_max);
            end
            // drop ready while a stall is running, raise it otherwise
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                 expected_views.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Offer one command word, hold it until accepted, then predict its result.
    // Valid stays high on return so a back-to-back word follows without a bubble.
    task automatic send_command(logic [CMD_BITS-1:0] cmd, logic [DQ_VAL_BITS-1:0] val);
        int unsigned            gap;
        logic [S_DATA_BITS-1:0] word;
        deque_view_t            want;
        gap  = $urandom_range(0, gap_max);
        word = '0;
        word[S_CMD_LSB +: CMD_BITS]   = cmd;
        word[S_VAL_LSB +: FIELD_BITS] = val;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (s_tready !== 1'b1);
        want = apply_deque_command(cmd, val);
        expected_views.push_back(want);
        items_sent++;
        cmd_seen[cmd]++;
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_EMPTY) empty_refusals++;
        if (want.found) search_hits++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_views.size() != 0);
    endtask

    // Pick a value: half the time one already held (when any), so searches and removes hit
    function automatic logic [DQ_VAL_BITS-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r < 2 && mirror_count > 0) begin
            return mirror_vals[slot_of($urandom_range(0, mirror_count - 1))];
        end else if (r == 2) begin
            // narrow pool: duplicates exercise first-match removal
            return $urandom_range(0, 7);
        end
        return $urandom();
    endfunction

    // Every refused or neutral command against an empty deque
    task automatic test_empty_deque();
        send_command(CMD_QUERY, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'hFFFF_FFFF);
        send_command(CMD_CONTAINS, 32'h0);
        send_command(CMD_REMOVE, 32'h0);
        send_command(CMD_SPARE, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // Each command with extreme values, duplicates and a remove from the middle
    task automatic test_basic_commands();
        send_command(CMD_PUSH_FRONT, 32'h0000_0000);
        send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        send_command(CMD_PUSH_FRONT, 32'h8000_0001);
        send_command(CMD_PUSH_BACK, 32'h0000_0005);
        send_command(CMD_PUSH_FRONT, 32'h0000_0005);
        send_command(CMD_CONTAINS, 32'h0000_0005);
        send_command(CMD_CONTAINS, 32'h0000_0007);
        send_command(CMD_REMOVE, 32'h1234_5678);
        send_command(CMD_REMOVE, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 32'h0000_0005);
        send_command(CMD_QUERY, 32'hA5A5_A5A5);
        send_command(CMD_SPARE, 32'h5A5A_5A5A);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_BACK, 32'h0);
        send_command(CMD_REMOVE, 32'h0000_0000);
        drain_results();
    endtask

    // Hold the receiver off for a long stretch while more pushes than the depth keep
    // coming, so the block backs up, stalls its input and overflows the store; then
    // search and remove at both ends of a full deque, and drain it back to empty.
    task automatic test_full_store();
        gap_max      = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < DQ_DEPTH + 4; i++) begin
            send_command((i % 2 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom());
        end
        gap_max = IDLE_MAX;
        // search walks the full depth before it hits the back entry
        send_command(CMD_CONTAINS, mirror_vals[slot_of(mirror_count - 1)]);
        send_command(CMD_REMOVE, mirror_vals[slot_of(mirror_count - 1)]);
        send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF);
        // longest compaction: match at the front
        send_command(CMD_REMOVE, mirror_vals[mirror_front]);
        send_command(CMD_PUSH_FRONT, 32'h0);
        send_command(CMD_CONTAINS, 32'hDEAD_0000 ^ mirror_vals[mirror_front]);
        drain_results();
        while (mirror_count > 0) begin
            send_command((mirror_count % 2 == 0) ? CMD_POP_FRONT : CMD_POP_BACK, 32'h0);
        end
        send_command(CMD_POP_FRONT, 32'h0);
        drain_results();
    endtask

    // Random commands biased toward filling or draining, flipping now and then
    task automatic test_random_mix(int unsigned n_items, int unsigned gmax, int unsigned smax);
        int unsigned         pick;
        logic [CMD_BITS-1:0] cmd;
        bit                  filling;
        gap_max   = gmax;
        stall_max = smax;
        filling   = 1'b1;
        for (int unsigned i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 29) == 0) filling = !filling;
            pick = $urandom_range(0, 99);
            if (filling) begin
                if (pick < 30)      cmd = CMD_PUSH_FRONT;
                else if (pick < 60) cmd = CMD_PUSH_BACK;
                else if (pick < 65) cmd = CMD_POP_FRONT;
                else if (pick < 70) cmd = CMD_POP_BACK;
                else if (pick < 80) cmd = CMD_CONTAINS;
                else if (pick < 90) cmd = CMD_REMOVE;
                else if (pick < 97) cmd = CMD_QUERY;
                else                cmd = CMD_SPARE;
            end else begin
                if (pick < 10)      cmd = CMD_PUSH_FRONT;
                else if (pick < 20) cmd = CMD_PUSH_BACK;
                else if (pick < 40) cmd = CMD_POP_FRONT;
                else if (pick < 60) cmd = CMD_POP_BACK;
                else if (pick < 75) cmd = CMD_CONTAINS;
                else if (pick < 90) cmd = CMD_REMOVE;
                else if (pick < 97) cmd = CMD_QUERY;
                else                cmd = CMD_SPARE;
            end
            send_command(cmd, pick_value());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RST_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_deque();
        test_basic_commands();
        test_full_store();
        // idle on both sides, then none, then one side at a time
        test_random_mix(200, IDLE_MAX, IDLE_MAX);
        test_random_mix(195, 0, 0);
        test_random_mix(195, IDLE_MAX, 0);
        test_random_mix(195, 0, IDLE_MAX);

        // let any stray word show up before the verdict
        repeat (2 * DQ_DEPTH + 16) @(posedge aclk);

        $display("Covered %0d commands: %0d push, %0d pop, %0d search, %0d remove, %0d query",
                 items_sent, cmd_seen[CMD_PUSH_FRONT] + cmd_seen[CMD_PUSH_BACK],
                 cmd_seen[CMD_POP_FRONT] + cmd_seen[CMD_POP_BACK], cmd_seen[CMD_CONTAINS],
                 cmd_seen[CMD_REMOVE], cmd_seen[CMD_QUERY] + cmd_seen[CMD_SPARE]);
        $display("Checked %0d results: %0d dropped pushes on full, %0d refusals on empty, %0d hits",
                 results_seen, full_drops, empty_refusals, search_hits);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: bounded_deque_with_search_unit.f
hw/rtl/bdqs_pkg.sv
hw/rtl/bounded_deque_with_search_unit.sv
hw/rtl/bdqs_checker.sv
verif/tb.sv
